// ----- rtl/sprs_pkg.sv -----
// Shared widths, register indexes and pipeline records for the sprite rect setup unit.
package sprs_pkg;

  localparam int CFG_W      = 11;
  localparam int POS_W      = 16;
  localparam int SCALE_W    = 16;
  localparam int OFF_W      = 11;
  localparam int SIZE_W     = 8;
  localparam int COORD_W    = 24;
  localparam int TEX_W      = 32;
  localparam int STEP_W     = 21;
  localparam int LIM_W      = CFG_W + 2;
  localparam int NUM_W      = 20;
  localparam int DEN_W      = 18;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = NUM_W / DIV_STEP;
  localparam int LATENCY    = DIV_STAGES + 5;

  localparam logic REG_SCREEN_W = 1'b0;
  localparam logic REG_SCREEN_H = 1'b1;

  typedef struct packed {
    logic [DEN_W-1:0]   w;
    logic [COORD_W-1:0] ul;
    logic [COORD_W-1:0] lr;
    logic               ok;
    logic               neg;
    logic [TEX_W-1:0]   s0;
  } sprs_side_t;

endpackage

// ----- rtl/scaled_sprite_rect_setup_unit.sv -----
// Top level: config registers, pipeline valid chain and result masking.
// Throughput: one beat per cycle unless a stalled output beat holds it;
// the five-stage division pipeline sets the depth.
// A stalled output beat holds the whole pipeline in place.
// Reset clears all valid bits and sets screen size to 320 by 240.
module scaled_sprite_rect_setup_unit import sprs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [POS_W-1:0]    pos_x,
  input  logic [POS_W-1:0]    pos_y,
  input  logic [SCALE_W-1:0]  scale_x,
  input  logic [SCALE_W-1:0]  scale_y,
  input  logic                flip_x,
  input  logic                flip_y,
  input  logic [OFF_W-1:0]    part_off_x,
  input  logic [OFF_W-1:0]    part_off_y,
  input  logic [SIZE_W-1:0]   tex_w,
  input  logic [SIZE_W-1:0]   tex_h,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                drawn,
  output logic [COORD_W-1:0]  rect_ulx,
  output logic [COORD_W-1:0]  rect_uly,
  output logic [COORD_W-1:0]  rect_lrx,
  output logic [COORD_W-1:0]  rect_lry,
  output logic [TEX_W-1:0]    tex_s,
  output logic [TEX_W-1:0]    tex_t,
  output logic [STEP_W-1:0]   step_s,
  output logic [STEP_W-1:0]   step_t
);

  logic [CFG_W-1:0]   screen_w;
  logic [CFG_W-1:0]   screen_h;
  logic [LATENCY-1:0] vld;
  logic               adv;
  logic               ok_x, ok_y;
  logic [COORD_W-1:0] ulx, uly, lrx, lry;
  logic [TEX_W-1:0]   s, t;
  logic [STEP_W-1:0]  ds, dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w <= CFG_W'(320);
      screen_h <= CFG_W'(240);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SCREEN_W: screen_w <= cfg_data;
        REG_SCREEN_H: screen_h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv       = !vld[LATENCY-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  sprs_axis u_x (
    .clk (clk), .en (adv), .lim ({screen_w, 2'b00}),
    .pos (pos_x), .scale (scale_x), .flip (flip_x), .off (part_off_x), .size (tex_w),
    .ok (ok_x), .ul (ulx), .lr (lrx), .start (s), .step (ds)
  );

  sprs_axis u_y (
    .clk (clk), .en (adv), .lim ({screen_h, 2'b00}),
    .pos (pos_y), .scale (scale_y), .flip (flip_y), .off (part_off_y), .size (tex_h),
    .ok (ok_y), .ul (uly), .lr (lry), .start (t), .step (dt)
  );

  assign drawn    = ok_x && ok_y;
  assign rect_ulx = drawn ? ulx : '0;
  assign rect_uly = drawn ? uly : '0;
  assign rect_lrx = drawn ? lrx : '0;
  assign rect_lry = drawn ? lry : '0;
  assign tex_s    = drawn ? s : '0;
  assign tex_t    = drawn ? t : '0;
  assign step_s   = drawn ? ds : '0;
  assign step_t   = drawn ? dt : '0;

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drawn |-> rect_lrx == '0 && tex_s == '0 && step_t == '0)
    else $error("rejected beat carries nonzero fields");
  a_rect_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && drawn |-> rect_ulx < rect_lrx && rect_uly < rect_lry)
    else $error("drawn rectangle is empty");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted beat lost at pipeline entry");
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ----- rtl/sprs_div_stage.sv -----
// One registered group of restoring division steps with sideband.
module sprs_div_stage import sprs_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] n_in,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [NUM_W-1:0] q_in,
  input  sprs_side_t       side_in,
  output logic [NUM_W-1:0] n_out,
  output logic [DEN_W-1:0] rem_out,
  output logic [NUM_W-1:0] q_out,
  output sprs_side_t       side_out
);

  logic [NUM_W-1:0] n_next;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] q_next;

  always_comb begin
    logic [DEN_W:0] r;
    n_next   = n_in;
    rem_next = rem_in;
    q_next   = q_in;
    for (int b = 0; b < DIV_STEP; b++) begin
      r = {rem_next, n_next[NUM_W-1]};
      n_next = {n_next[NUM_W-2:0], 1'b0};
      if (r >= {1'b0, side_in.w}) begin
        r = r - {1'b0, side_in.w};
        q_next = {q_next[NUM_W-2:0], 1'b1};
      end else begin
        q_next = {q_next[NUM_W-2:0], 1'b0};
      end
      rem_next = r[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out    <= n_next;
      rem_out  <= rem_next;
      q_out    <= q_next;
      side_out <= side_in;
    end
  end

endmodule

// ----- rtl/sprs_axis.sv -----
// One axis: scale, rectangle edges, texture step division and clip advance.
module sprs_axis import sprs_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [LIM_W-1:0]    lim,
  input  logic [POS_W-1:0]    pos,
  input  logic [SCALE_W-1:0]  scale,
  input  logic                flip,
  input  logic [OFF_W-1:0]    off,
  input  logic [SIZE_W-1:0]   size,
  output logic                ok,
  output logic [COORD_W-1:0]  ul,
  output logic [COORD_W-1:0]  lr,
  output logic [TEX_W-1:0]    start,
  output logic [STEP_W-1:0]   step
);

  // stage 1: products
  logic signed [27:0] prod_o;
  logic [23:0]        prod_w;
  logic [POS_W-1:0]   pos1;
  logic               flip1;
  logic [SIZE_W-1:0]  size1;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_o <= $signed({{17{off[OFF_W-1]}}, off}) * $signed({12'b0, scale});
      prod_w <= {16'b0, size} * {8'b0, scale};
      pos1   <= pos;
      flip1  <= flip;
      size1  <= size;
    end
  end

  // stage 2: edges, visibility, division setup
  logic [27:0]        o_bias;
  logic [COORD_W-1:0] o_ext;
  logic [COORD_W-1:0] pos_ext;
  logic [DEN_W-1:0]   w2;
  logic [COORD_W-1:0] ul2;
  logic [COORD_W-1:0] lr2;
  sprs_side_t         side2;
  logic [NUM_W-1:0]   num2;
  logic [NUM_W-1:0]   n_st  [DIV_STAGES+1];
  logic [DEN_W-1:0]   r_st  [DIV_STAGES+1];
  logic [NUM_W-1:0]   q_st  [DIV_STAGES+1];
  sprs_side_t         sd_st [DIV_STAGES+1];

  always_comb begin
    o_bias  = 28'(prod_o + $signed({22'b0, {6{prod_o[27]}}}));
    o_ext   = {{2{o_bias[27]}}, o_bias[27:6]};
    pos_ext = {{(COORD_W-POS_W){pos1[POS_W-1]}}, pos1};
    w2      = prod_w[23:6];
    if (!flip1) begin
      ul2 = pos_ext + o_ext;
      lr2 = ul2 + {{(COORD_W-DEN_W){1'b0}}, w2};
    end else begin
      lr2 = pos_ext - o_ext;
      ul2 = lr2 - {{(COORD_W-DEN_W){1'b0}}, w2};
    end
    side2.w   = w2;
    side2.ul  = ul2;
    side2.lr  = lr2;
    side2.ok  = ($signed(ul2) < $signed({{(COORD_W-LIM_W){1'b0}}, lim}))
                && ($signed(lr2) > 0) && (w2 != '0);
    side2.neg = (size1 == '0) ^ flip1;
    side2.s0  = flip1 ? ((TEX_W'(size1) - 1) << 5) : '0;
    num2      = (size1 == '0) ? NUM_W'(4096) : {size1 - SIZE_W'(1), 12'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_st[0]  <= num2;
      r_st[0]  <= '0;
      q_st[0]  <= '0;
      sd_st[0] <= side2;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    sprs_div_stage u_stage (
      .clk      (clk),
      .en       (en),
      .n_in     (n_st[k]),
      .rem_in   (r_st[k]),
      .q_in     (q_st[k]),
      .side_in  (sd_st[k]),
      .n_out    (n_st[k+1]),
      .rem_out  (r_st[k+1]),
      .q_out    (q_st[k+1]),
      .side_out (sd_st[k+1])
    );
  end

  // signed step and clip magnitude
  sprs_side_t         sd_m1;
  logic [STEP_W-1:0]  d_m1;
  logic [COORD_W-1:0] mag_m1;
  sprs_side_t         sd_m2;
  logic [STEP_W-1:0]  d_m2;
  logic signed [45:0] prod_m2;

  always_ff @(posedge clk) begin
    if (en) begin
      sd_m1  <= sd_st[DIV_STAGES];
      d_m1   <= sd_st[DIV_STAGES].neg ? -{1'b0, q_st[DIV_STAGES]} : {1'b0, q_st[DIV_STAGES]};
      mag_m1 <= sd_st[DIV_STAGES].ul[COORD_W-1] ? -sd_st[DIV_STAGES].ul : '0;
      sd_m2  <= sd_m1;
      d_m2   <= d_m1;
      prod_m2 <= $signed({22'b0, mag_m1}) * $signed({{25{d_m1[STEP_W-1]}}, d_m1});
      ok     <= sd_m2.ok;
      ul     <= sd_m2.ul[COORD_W-1] ? '0 : sd_m2.ul;
      lr     <= sd_m2.lr;
      start  <= sd_m2.s0 + prod_m2[38:7];
      step   <= d_m2;
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the scaled sprite rect setup unit: directed table plus random parts.
module testbench;
  import sprs_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
    logic               fx;
    logic               fy;
    logic [OFF_W-1:0]   ox;
    logic [OFF_W-1:0]   oy;
    logic [SIZE_W-1:0]  tw;
    logic [SIZE_W-1:0]  th;
  } part_t;

  typedef struct packed {
    logic               drawn;
    logic [COORD_W-1:0] ulx;
    logic [COORD_W-1:0] uly;
    logic [COORD_W-1:0] lrx;
    logic [COORD_W-1:0] lry;
    logic [TEX_W-1:0]   s;
    logic [TEX_W-1:0]   t;
    logic [STEP_W-1:0]  ds;
    logic [STEP_W-1:0]  dt;
  } rect_t;

  typedef struct packed {
    part_t p;
    logic  typed;
    rect_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_idx = REG_SCREEN_W;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  part_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rect_t got;

  scaled_sprite_rect_setup_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(cur.px), .pos_y(cur.py), .scale_x(cur.sx), .scale_y(cur.sy),
    .flip_x(cur.fx), .flip_y(cur.fy), .part_off_x(cur.ox), .part_off_y(cur.oy),
    .tex_w(cur.tw), .tex_h(cur.th),
    .out_valid(out_valid), .out_ready(out_ready), .drawn(got.drawn),
    .rect_ulx(got.ulx), .rect_uly(got.uly), .rect_lrx(got.lrx), .rect_lry(got.lry),
    .tex_s(got.s), .tex_t(got.t), .step_s(got.ds), .step_t(got.dt)
  );

  always #5 clk = ~clk;

  logic [CFG_W-1:0] scr_w = 11'd320;
  logic [CFG_W-1:0] scr_h = 11'd240;
  rect_t rect_q[$];
  row_t  table_q[$];
  logic  cur_typed = 1'b0;
  rect_t cur_rect = '0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    errors = 0;
  int    cycles = 0;

  function automatic void span(longint pos, longint scale, bit flip, longint off,
                               longint size, output longint ul, output longint lr);
    longint o, w;
    o = (off * scale) / 64;
    w = (size * scale) / 64;
    if (!flip) begin
      ul = pos + o;
      lr = ul + w;
    end else begin
      lr = pos - o;
      ul = lr - w;
    end
  endfunction

  function automatic void texel_walk(inout longint ul, input longint lr, input longint size,
                                     input bit flip, output longint st, output longint stp);
    longint d, s;
    d = ((size - 1) * 4096) / (lr - ul);
    s = 0;
    if (flip) begin
      s = (size - 1) * 32;
      d = -d;
    end
    if (ul < 0) begin
      s = s + ((-ul * d) >>> 7);
      ul = 0;
    end
    st = s;
    stp = d;
  endfunction

  function automatic rect_t sprite_rect(part_t p);
    longint ulx, uly, lrx, lry, s, t, ds, dt;
    rect_t r;
    r = '0;
    span(longint'($signed(p.px)), longint'(p.sx), p.fx, longint'($signed(p.ox)),
         longint'(p.tw), ulx, lrx);
    span(longint'($signed(p.py)), longint'(p.sy), p.fy, longint'($signed(p.oy)),
         longint'(p.th), uly, lry);
    if (!(ulx < longint'(scr_w) * 4 && uly < longint'(scr_h) * 4)) return r;
    if (!(lrx > 0 && lry > 0 && ulx < lrx && uly < lry)) return r;
    texel_walk(ulx, lrx, longint'(p.tw), p.fx, s, ds);
    texel_walk(uly, lry, longint'(p.th), p.fy, t, dt);
    r.drawn = 1'b1;
    r.ulx = ulx[COORD_W-1:0];
    r.uly = uly[COORD_W-1:0];
    r.lrx = lrx[COORD_W-1:0];
    r.lry = lry[COORD_W-1:0];
    r.s = s[TEX_W-1:0];
    r.t = t[TEX_W-1:0];
    r.ds = ds[STEP_W-1:0];
    r.dt = dt[STEP_W-1:0];
    return r;
  endfunction

  function automatic part_t rand_part();
    part_t p;
    p = part_t'({$urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(99) < 80) begin
      p.px = POS_W'($urandom_range(4800) - 400);
      p.py = POS_W'($urandom_range(4800) - 400);
      p.sx = SCALE_W'($urandom_range(1024));
      p.sy = SCALE_W'($urandom_range(1024));
      p.ox = OFF_W'($urandom_range(160) - 80);
      p.oy = OFF_W'($urandom_range(160) - 80);
      p.tw = SIZE_W'($urandom_range(64, 1));
      p.th = SIZE_W'($urandom_range(64, 1));
    end
    return p;
  endfunction

  task automatic cmp(string name, logic [TEX_W-1:0] e, logic [TEX_W-1:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    rect_t e;
    if (!rst && out_valid && out_ready) begin
      if (rect_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, got);
        errors++;
      end else begin
        e = rect_q.pop_front();
        cmp("drawn", TEX_W'(e.drawn), TEX_W'(got.drawn));
        cmp("rect_ulx", TEX_W'(e.ulx), TEX_W'(got.ulx));
        cmp("rect_uly", TEX_W'(e.uly), TEX_W'(got.uly));
        cmp("rect_lrx", TEX_W'(e.lrx), TEX_W'(got.lrx));
        cmp("rect_lry", TEX_W'(e.lry), TEX_W'(got.lry));
        cmp("tex_s", e.s, got.s);
        cmp("tex_t", e.t, got.t);
        cmp("step_s", TEX_W'(e.ds), TEX_W'(got.ds));
        cmp("step_t", TEX_W'(e.dt), TEX_W'(got.dt));
      end
    end
    if (!rst && in_valid && in_ready)
      rect_q.push_back(cur_typed ? cur_rect : sprite_rect(cur));
  end

  task automatic send(part_t p, logic typed, rect_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cur <= p;
    in_valid <= 1'b1;
    cur_typed = typed;
    cur_rect = r;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rect_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_screen(int w, int h);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= REG_SCREEN_W;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    cfg_idx <= REG_SCREEN_H;
    cfg_data <= CFG_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = CFG_W'(w);
    scr_h = CFG_W'(h);
    @(posedge clk);
  endtask

  task automatic add_row(part_t p, logic typed, rect_t r);
    row_t row;
    row.p = p;
    row.typed = typed;
    row.r = r;
    table_q.push_back(row);
  endtask

  int scr_list[6][2] = '{'{1, 1}, '{1024, 1024}, '{0, 0}, '{2047, 2047},
                         '{640, 480}, '{320, 240}};
  int idle_list[4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{32, 32}};

  initial begin
    part_t p;
    rect_t r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    p = '{px: 0, py: 0, sx: 256, sy: 256, fx: 0, fy: 0, ox: 0, oy: 0, tw: 16, th: 16};
    r = '{drawn: 1, ulx: 0, uly: 0, lrx: 64, lry: 64, s: 0, t: 0, ds: 960, dt: 960};
    add_row(p, 1'b1, r);
    p.sx = 0;
    add_row(p, 1'b1, '0);
    p.sx = 256; p.sy = 0;
    add_row(p, 1'b1, '0);
    p.sy = 256; p.px = 16'd1280;
    add_row(p, 1'b1, '0);
    p.px = 0; p.py = 16'd960;
    add_row(p, 1'b1, '0);
    p.py = 0; p.px = 16'h8000;
    add_row(p, 1'b1, '0);
    p.px = 0; p.py = 16'h8000;
    add_row(p, 1'b1, '0);
    p = '{px: 400, py: 300, sx: 256, sy: 256, fx: 1, fy: 1, ox: 5, oy: -3, tw: 16, th: 8};
    add_row(p, 1'b0, '0);
    p = '{px: -20, py: -37, sx: 384, sy: 200, fx: 0, fy: 0, ox: 0, oy: 2, tw: 20, th: 30};
    add_row(p, 1'b0, '0);
    p.fx = 1; p.fy = 1;
    add_row(p, 1'b0, '0);
    p = '{px: 100, py: 100, sx: 256, sy: 256, fx: 0, fy: 1, ox: 0, oy: 0, tw: 0, th: 0};
    add_row(p, 1'b0, '0);
    p.fx = 1; p.fy = 0;
    add_row(p, 1'b0, '0);
    p = '{px: 16'h7fff, py: 16'h7fff, sx: 16'hffff, sy: 16'hffff, fx: 1, fy: 1,
          ox: 11'h3ff, oy: 11'h3ff, tw: 255, th: 255};
    add_row(p, 1'b0, '0);
    p = '{px: 16'h8000, py: 16'h8000, sx: 16'hffff, sy: 16'hffff, fx: 0, fy: 0,
          ox: 11'h3ff, oy: 11'h3ff, tw: 255, th: 255};
    add_row(p, 1'b0, '0);
    p.ox = 11'h400; p.oy = 11'h400; p.fx = 1; p.fy = 1;
    add_row(p, 1'b0, '0);
    p = '{px: 0, py: 0, sx: 16'hffff, sy: 16'hffff, fx: 1, fy: 0,
          ox: 11'h400, oy: 11'h3ff, tw: 1, th: 255};
    add_row(p, 1'b0, '0);
    p = '{px: 1276, py: 956, sx: 1, sy: 1, fx: 0, fy: 0, ox: 0, oy: 0, tw: 255, th: 255};
    add_row(p, 1'b0, '0);

    foreach (table_q[i]) send(table_q[i].p, table_q[i].typed, table_q[i].r);

    foreach (scr_list[c]) begin
      set_screen(scr_list[c][0], scr_list[c][1]);
      foreach (idle_list[k]) begin
        idle_pct = idle_list[k][0];
        stall_pct = idle_list[k][1];
        repeat (76) send(rand_part(), 1'b0, '0);
      end
      stall_pct = 0;
      idle_pct = 0;
    end

    drain();
    if (errors == 0 && rect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sprs_pkg.sv
rtl/sprs_div_stage.sv
rtl/sprs_axis.sv
rtl/scaled_sprite_rect_setup_unit.sv
dv/testbench.sv
